### hw/rtl/rdb_pkg.sv
// Shared constants, types and lane functions for the RGBA 2x2 downscaler.
package rdb_pkg;

    localparam int MAX_SOURCE_WIDTH  = 4096;
    localparam int MAX_SOURCE_HEIGHT = 16384;
    localparam int MAX_WIDTH_IN_USE  = MAX_SOURCE_WIDTH - MAX_SOURCE_WIDTH % 2;
    localparam int LINE_DEPTH        = MAX_SOURCE_WIDTH / 2;
    localparam int LINE_ADDR_W       = $clog2(LINE_DEPTH);
    localparam int COL_W             = $clog2(MAX_SOURCE_WIDTH);
    localparam int ROW_W             = $clog2(MAX_SOURCE_HEIGHT);
    localparam int SRC_WIDTH_W       = 13;
    localparam int SRC_HEIGHT_W      = 15;
    localparam int CFG_DATA_W        = 15;
    localparam int PIXEL_W           = 32;

    localparam logic [PIXEL_W-1:0] SEVEN_BIT_MASK = 32'h7F7F_7F7F;

    typedef enum logic [0:0] {
        CFG_SOURCE_WIDTH  = 1'b0,
        CFG_SOURCE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef logic [PIXEL_W-1:0] pixel_t;

    // per-channel truncating average of a horizontal pair
    function automatic pixel_t pair_average(input pixel_t a, input pixel_t b);
        pixel_t     r;
        logic [8:0] s;
        r = '0;
        for (int k = 0; k < 4; k++)
        begin
            s = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
            r[8*k +: 8] = s[8:1];
        end
        return r;
    endfunction

    // (u>>1)+(l>>1) per channel; lane sums stay below 256
    function automatic pixel_t half_sum(input pixel_t u, input pixel_t l);
        return ((u >> 1) & SEVEN_BIT_MASK) + ((l >> 1) & SEVEN_BIT_MASK);
    endfunction

endpackage

### hw/rtl/rdb_ram.sv
// Generic single-port RAM with registered read.
module rdb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/rgba_downscale_by_two_top.sv
// Top level of the RGBA8 2x2 box-filter downscaler.
// Takes one source pixel word per clock in raster order and emits one averaged
// target pixel for each 2x2 block, on the second pixel of each pair on odd rows.
// A word is accepted every cycle while the output side keeps up. The edge that
// accepts a result's last source word loads the pair register and the registered
// read of the 2048 x 32 single-port line RAM; the vertical combine is loaded into
// the output register when that stage advances.
// The line RAM sees at most one access per accepted word.
// m_axis_tlast marks the last target pixel of a row, m_axis_tuser the last of
// the frame. Widths above 4096 are limited to 4096; odd sizes are rounded down.
module rgba_downscale_by_two_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [rdb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,   // [31:0] in_pixel
    input  logic                              s_axis_tuser,   // [0] frame_start
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,   // [31:0] out_pixel
    output logic                              m_axis_tlast,   // row_end
    output logic                              m_axis_tuser    // [0] frame_end
);

    logic [rdb_pkg::SRC_WIDTH_W-1:0]  src_width_reg;
    logic [rdb_pkg::SRC_HEIGHT_W-1:0] src_height_reg;
    logic [rdb_pkg::COL_W-1:0]        col_reg, col_next;
    logic [rdb_pkg::ROW_W-1:0]        row_reg, row_next;
    rdb_pkg::pixel_t                  left_pixel_reg;

    logic                             s1_valid_reg;
    rdb_pkg::pixel_t                  s1_pair_reg;
    logic                             s1_row_end_reg;
    logic                             s1_frame_end_reg;

    logic                             out_valid_reg;
    rdb_pkg::pixel_t                  out_pixel_reg;
    logic                             out_row_end_reg;
    logic                             out_frame_end_reg;

    logic [rdb_pkg::SRC_WIDTH_W-1:0]  w_use;
    logic [rdb_pkg::SRC_HEIGHT_W-1:0] h_use;
    logic [rdb_pkg::COL_W-1:0]        x;
    logic [rdb_pkg::ROW_W-1:0]        y;
    logic [rdb_pkg::COL_W:0]          x_inc;
    logic [rdb_pkg::ROW_W:0]          y_inc;
    logic                             row_wrap;
    logic                             frame_wrap;
    logic                             s_accept;
    logic                             s1_adv;
    logic                             pair_word;
    logic                             emit;
    logic                             ram_en;
    rdb_pkg::pixel_t                  pair;
    rdb_pkg::pixel_t                  upper_pair;

    // size in use: low bit cleared, at least 2, at most the maximum
    always_comb
    begin
        w_use = {src_width_reg[rdb_pkg::SRC_WIDTH_W-1:1], 1'b0};
        if (w_use < rdb_pkg::SRC_WIDTH_W'(2))
        begin
            w_use = rdb_pkg::SRC_WIDTH_W'(2);
        end
        else if (int'(w_use) > rdb_pkg::MAX_WIDTH_IN_USE)
        begin
            w_use = rdb_pkg::SRC_WIDTH_W'(rdb_pkg::MAX_WIDTH_IN_USE);
        end
        h_use = {src_height_reg[rdb_pkg::SRC_HEIGHT_W-1:1], 1'b0};
        if (h_use < rdb_pkg::SRC_HEIGHT_W'(2))
        begin
            h_use = rdb_pkg::SRC_HEIGHT_W'(2);
        end
        else if (h_use > rdb_pkg::SRC_HEIGHT_W'(rdb_pkg::MAX_SOURCE_HEIGHT))
        begin
            h_use = rdb_pkg::SRC_HEIGHT_W'(rdb_pkg::MAX_SOURCE_HEIGHT);
        end
    end

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign x          = s_axis_tuser ? '0 : col_reg;
    assign y          = s_axis_tuser ? '0 : row_reg;
    assign x_inc      = {1'b0, x} + 1'b1;
    assign y_inc      = {1'b0, y} + 1'b1;
    assign row_wrap   = rdb_pkg::SRC_WIDTH_W'(x_inc) >= w_use;
    assign frame_wrap = row_wrap && (rdb_pkg::SRC_HEIGHT_W'(y_inc) >= h_use);
    assign pair_word  = x[0];
    assign emit       = pair_word && y[0];
    assign ram_en     = s_accept && pair_word;
    assign pair       = rdb_pkg::pair_average(left_pixel_reg, s_axis_tdata);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_accept)
        begin
            if (row_wrap)
            begin
                col_next = '0;
                row_next = frame_wrap ? '0 : y_inc[rdb_pkg::ROW_W-1:0];
            end
            else
            begin
                col_next = x_inc[rdb_pkg::COL_W-1:0];
                row_next = y;
            end
        end
    end

    rdb_ram #(
        .WIDTH (rdb_pkg::PIXEL_W),
        .DEPTH (rdb_pkg::LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (!y[0]),
        .addr  (x[rdb_pkg::COL_W-1:1]),
        .wdata (pair),
        .rdata (upper_pair)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= rdb_pkg::SRC_WIDTH_W'(64);
            src_height_reg <= rdb_pkg::SRC_HEIGHT_W'(64);
            col_reg        <= '0;
            row_reg        <= '0;
            left_pixel_reg <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (rdb_pkg::cfg_index_t'(cfg_index))
                    rdb_pkg::CFG_SOURCE_WIDTH:
                        src_width_reg <= cfg_data[rdb_pkg::SRC_WIDTH_W-1:0];
                    rdb_pkg::CFG_SOURCE_HEIGHT:
                        src_height_reg <= cfg_data;
                    default: ;
                endcase
            end
            col_reg <= col_next;
            row_reg <= row_next;
            if (s_accept && !pair_word)
            begin
                left_pixel_reg <= s_axis_tdata;
            end
            if (s_accept)
            begin
                s1_valid_reg <= emit;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && emit)
        begin
            s1_pair_reg      <= pair;
            s1_row_end_reg   <= row_wrap;
            s1_frame_end_reg <= frame_wrap;
        end
        if (s1_adv)
        begin
            out_pixel_reg     <= rdb_pkg::half_sum(upper_pair, s1_pair_reg);
            out_row_end_reg   <= s1_row_end_reg;
            out_frame_end_reg <= s1_frame_end_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pixel_reg;
    assign m_axis_tlast  = out_row_end_reg;
    assign m_axis_tuser  = out_frame_end_reg;

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg)
        else $error("stalled result lost");

    a_emit_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && emit |=> s1_valid_reg)
        else $error("result not staged");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |-> !s_axis_tready && !ram_en)
        else $error("input taken while result stalled");

    a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_frame_end_reg |-> out_row_end_reg)
        else $error("frame end without row end");

endmodule

### bench/rgba_downscale_by_two_top_test.sv
// Self-checking testbench for the RGBA8 2x2 box-filter downscaler.
module rgba_downscale_by_two_top_test;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 6;
    localparam int WIDE_WORDS   = 520;
    localparam int RANDOM_WORDS = 1150;
    localparam int CALM_WORDS   = 300;

    typedef struct packed {
        rdb_pkg::pixel_t pixel;
        logic            row_end;
        logic            frame_end;
    } thumb_t;

    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           cfg_we        = 1'b0;
    logic                           cfg_index     = 1'b0;
    logic [rdb_pkg::CFG_DATA_W-1:0] cfg_data      = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [31:0]                    s_axis_tdata  = '0;
    logic                           s_axis_tuser  = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [31:0]                    m_axis_tdata;
    logic                           m_axis_tlast;
    logic                           m_axis_tuser;

    // predictor state
    logic [rdb_pkg::SRC_WIDTH_W-1:0]  width_reg  = 13'd64;
    logic [rdb_pkg::SRC_HEIGHT_W-1:0] height_reg = 15'd64;
    int                               col        = 0;
    int                               row        = 0;
    rdb_pkg::pixel_t                  left_word  = '0;
    rdb_pkg::pixel_t                  upper_pairs [rdb_pkg::LINE_DEPTH];
    bit                               upper_written [rdb_pkg::LINE_DEPTH];
    thumb_t                           pending_thumbs [$];

    bit send_idle  = 1'b0;
    bit sink_idle  = 1'b0;
    int stall_left = 0;
    int errors     = 0;

    rgba_downscale_by_two_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic int active_width();
        int w;
        w = int'(width_reg) & ~1;
        if (w < 2)
            w = 2;
        if (w > rdb_pkg::MAX_SOURCE_WIDTH)
            w = rdb_pkg::MAX_SOURCE_WIDTH & ~1;
        return w;
    endfunction

    function automatic int active_height();
        int h;
        h = int'(height_reg) & ~1;
        if (h < 2)
            h = 2;
        if (h > rdb_pkg::MAX_SOURCE_HEIGHT)
            h = rdb_pkg::MAX_SOURCE_HEIGHT;
        return h;
    endfunction

    function automatic rdb_pkg::pixel_t pair_mean(rdb_pkg::pixel_t a, rdb_pkg::pixel_t b);
        rdb_pkg::pixel_t m;
        m = '0;
        for (int k = 0; k < 4; k++)
            m[8*k +: 8] = 8'((int'(a[8*k +: 8]) + int'(b[8*k +: 8])) >> 1);
        return m;
    endfunction

    // 7-bit precision: each half is truncated before the add
    function automatic rdb_pkg::pixel_t vertical_mean(rdb_pkg::pixel_t u,
                                                      rdb_pkg::pixel_t l);
        rdb_pkg::pixel_t m;
        m = '0;
        for (int k = 0; k < 4; k++)
            m[8*k +: 8] = 8'((int'(u[8*k +: 8]) >> 1) + (int'(l[8*k +: 8]) >> 1));
        return m;
    endfunction

    function automatic bit reads_blank_entry();
        return (col % 2 == 1) && (row % 2 == 1) && !upper_written[col / 2];
    endfunction

    function automatic void downscale_word(rdb_pkg::pixel_t px, logic start);
        int              w;
        int              h;
        int              x;
        int              y;
        bit              wrap_row;
        bit              wrap_frame;
        rdb_pkg::pixel_t pair;
        w = active_width();
        h = active_height();
        if (start)
        begin
            col = 0;
            row = 0;
        end
        x = col;
        y = row;
        wrap_row   = (x + 1) >= w;
        wrap_frame = wrap_row && (y + 1) >= h;
        if (x % 2 == 0)
            left_word = px;
        else
        begin
            pair = pair_mean(left_word, px);
            if (y % 2 == 0)
            begin
                upper_pairs[x / 2]   = pair;
                upper_written[x / 2] = 1'b1;
            end
            else
                pending_thumbs.push_back({vertical_mean(upper_pairs[x / 2], pair),
                                          wrap_row, wrap_frame});
        end
        if (wrap_row)
        begin
            col = 0;
            row = wrap_frame ? 0 : y + 1;
        end
        else
            col = x + 1;
    endfunction

    function automatic rdb_pkg::pixel_t random_pixel();
        case ($urandom_range(0, 15))
            0:       return '1;
            1:       return '0;
            default: return rdb_pkg::pixel_t'($urandom);
        endcase
    endfunction

    function automatic void note_error(string msg);
        errors++;
        if (errors <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function automatic void compare_thumb(thumb_t want);
        if (m_axis_tdata !== want.pixel || m_axis_tlast !== want.row_end ||
            m_axis_tuser !== want.frame_end)
            note_error($sformatf("expected pixel %h row_end %b frame_end %b, got %h %b %b",
                                 want.pixel, want.row_end, want.frame_end,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser));
    endfunction

    // result side: random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (sink_idle && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 14);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_thumbs.size() == 0)
                note_error($sformatf("unexpected word %h row_end %b frame_end %b",
                                     m_axis_tdata, m_axis_tlast, m_axis_tuser));
            else
                compare_thumb(pending_thumbs.pop_front());
        end
    end

    task automatic send_word(input rdb_pkg::pixel_t px, input logic start);
        logic go;
        // never let an odd row read a line entry that was never written
        go = start || reads_blank_entry();
        if (send_idle && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tuser  <= go;
        do
            @(posedge clk);
        while (!s_axis_tready);
        downscale_word(px, go);
    endtask

    task automatic send_words(input int count, input logic start_first);
        for (int i = 0; i < count; i++)
            send_word(random_pixel(), (i == 0) && start_first);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_thumbs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input rdb_pkg::cfg_index_t idx,
                             input logic [rdb_pkg::CFG_DATA_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == rdb_pkg::CFG_SOURCE_WIDTH)
            width_reg = value[rdb_pkg::SRC_WIDTH_W-1:0];
        else
            height_reg = value[rdb_pkg::SRC_HEIGHT_W-1:0];
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_sizes(input int w, input int h);
        write_reg(rdb_pkg::CFG_SOURCE_WIDTH, rdb_pkg::CFG_DATA_W'(w));
        write_reg(rdb_pkg::CFG_SOURCE_HEIGHT, rdb_pkg::CFG_DATA_W'(h));
    endtask

    // a few words at the reset size, no frame start
    task automatic test_reset_size();
        send_words(4, 1'b0);
    endtask

    task automatic test_lane_extremes();
        rdb_pkg::pixel_t corners [16] = '{
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
            32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
            32'h0101_0101, 32'h0000_0000, 32'h01FE_807F, 32'hFE01_7F80
        };
        write_sizes(2, 2);
        for (int i = 0; i < 16; i++)
            send_word(corners[i], i % 4 == 0);
    endtask

    task automatic test_size_rounding();
        write_sizes(3, 3);
        send_words(4, 1'b1);
        write_sizes(0, 1);
        send_words(4, 1'b1);
        write_sizes(5, 0);
        send_words(8, 1'b1);
    endtask

    task automatic test_restart_mid_frame();
        write_sizes(4, 4);
        send_words(6, 1'b1);
        send_words(16, 1'b1);
    endtask

    // shrink width and height while the counters sit beyond the new ends
    task automatic test_counters_past_end();
        write_sizes(8, rdb_pkg::MAX_SOURCE_HEIGHT);
        send_words(29, 1'b1);
        write_reg(rdb_pkg::CFG_SOURCE_WIDTH, rdb_pkg::CFG_DATA_W'(4));
        send_words(1, 1'b0);
        send_words(6, 1'b0);
        write_reg(rdb_pkg::CFG_SOURCE_HEIGHT, rdb_pkg::CFG_DATA_W'(2));
        send_words(2, 1'b0);
    endtask

    task automatic test_widest_row();
        write_sizes('1, '1);
        send_idle = 1'b1;
        sink_idle = 1'b1;
        send_words(WIDE_WORDS, 1'b1);
        send_idle = 1'b0;
        sink_idle = 1'b0;
    endtask

    task automatic test_random_frames();
        int words;
        int w;
        int h;
        int n;
        words = 0;
        while (words < RANDOM_WORDS)
        begin
            send_idle = (words < RANDOM_WORDS - CALM_WORDS) && $urandom_range(0, 3) != 0;
            sink_idle = (words < RANDOM_WORDS - CALM_WORDS) && $urandom_range(0, 3) != 0;
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 17) : 2 * $urandom_range(1, 12);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9) : 2 * $urandom_range(1, 4);
            if (width_reg != w || height_reg != h)
                write_sizes(w, h);
            n = active_width() * active_height();
            if ($urandom_range(0, 7) == 0)
                n = $urandom_range(1, n);
            for (int i = 0; i < n; i++)
            begin
                if (i == 0)
                    send_word(random_pixel(), $urandom_range(0, 9) != 0);
                else
                    send_word(random_pixel(), $urandom_range(0, 49) == 0);
            end
            words += n;
        end
        send_idle = 1'b0;
        sink_idle = 1'b0;
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_size();
        test_lane_extremes();
        test_size_rounding();
        test_restart_mid_frame();
        test_counters_past_end();
        test_widest_row();
        test_random_frames();
        settle();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
